### rtl/smdu_pkg.sv
// Package for the SIMD multiply/divide unit: payload structs, sizes, commands.
// No dependencies.
package smdu_pkg;

    localparam int LANES      = 4;
    localparam int WORD_BITS  = 16;
    localparam int CELLS      = WORD_BITS;
    localparam int DEPTH      = CELLS + 1;

    typedef enum logic {
        CMD_MUL = 1'b0,
        CMD_DIV = 1'b1
    } cmd_t;

    typedef struct packed {
        logic        command;
        logic        vector_mode;
        logic [15:0] a_lane0;
        logic [15:0] a_lane1;
        logic [15:0] a_lane2;
        logic [15:0] a_lane3;
        logic [15:0] b_lane0;
        logic [15:0] b_lane1;
        logic [15:0] b_lane2;
        logic [15:0] b_lane3;
    } in_item_t;

    typedef struct packed {
        logic [15:0] high_lane0;
        logic [15:0] high_lane1;
        logic [15:0] high_lane2;
        logic [15:0] high_lane3;
        logic [15:0] low_lane0;
        logic [15:0] low_lane1;
        logic [15:0] low_lane2;
        logic [15:0] low_lane3;
        logic        zero_flag;
        logic        divide_by_zero;
    } out_item_t;

    // Per-lane working word carried down the cell chain.
    typedef struct packed {
        logic [WORD_BITS-1:0] rem;   // partial remainder
        logic [WORD_BITS-1:0] quo;   // dividend shifting out, quotient shifting in
        logic [WORD_BITS-1:0] div;   // divisor
        logic [2*WORD_BITS-1:0] prod; // product, formed in the first cell
    } lane_t;

    // Item-level control carried along with the lanes.
    typedef struct packed {
        logic valid;
        logic command;
        logic vector_mode;
    } ctl_t;

endpackage

### rtl/simd_mul_div_execute_unit_core.sv
// Path from input accept to output valid: 1 multiply/load cell, 16 division cells,
// 1 output register. Throughput: one item per cycle,
// set by the chain of per-bit division cells; the whole chain stalls together.
// Reset: rst_n asynchronous, active low, clears all valid bits.
// Top level of the SIMD multiply/divide unit. Depends on smdu_pkg, smdu_cell.
module simd_mul_div_execute_unit_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  smdu_pkg::in_item_t   in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output smdu_pkg::out_item_t  out_data
);
    import smdu_pkg::*;

    logic en;
    ctl_t ctl_c [DEPTH+1];
    lane_t [3:0] lanes_c [DEPTH+1];
    ctl_t ctl0_reg;
    lane_t [3:0] lanes0_reg;
    lane_t [3:0] lanes0_next;
    logic [15:0] a_w [4];
    logic [15:0] b_w [4];
    out_item_t out_next;
    out_item_t out_reg;
    logic out_valid_reg;
    logic fault;
    logic zero;
    logic used;

    // Whole chain moves when the output register can take a new item
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign a_w = '{in_data.a_lane0, in_data.a_lane1, in_data.a_lane2, in_data.a_lane3};
    assign b_w = '{in_data.b_lane0, in_data.b_lane1, in_data.b_lane2, in_data.b_lane3};

    // First cell: multiply, load division operands
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lanes0_next[i].rem  = '0;
            lanes0_next[i].quo  = a_w[i];
            lanes0_next[i].div  = b_w[i];
            lanes0_next[i].prod = a_w[i] * b_w[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl0_reg <= '0;
        else if (en)
            ctl0_reg <= '{valid: in_valid, command: in_data.command,
                          vector_mode: in_data.vector_mode};
    end

    always_ff @(posedge clk)
    begin
        if (en)
            lanes0_reg <= lanes0_next;
    end

    assign ctl_c[0]   = ctl0_reg;
    assign lanes_c[0] = lanes0_reg;

    // Division cells
    for (genvar g = 0; g < CELLS; g++)
    begin : g_cell
        smdu_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .ctl       (ctl_c[g]),
            .lanes     (lanes_c[g]),
            .ctl_reg   (ctl_c[g+1]),
            .lanes_reg (lanes_c[g+1])
        );
    end

    assign ctl_c[DEPTH]   = ctl_c[CELLS];
    assign lanes_c[DEPTH] = lanes_c[CELLS];

    // Assemble result: lanes in order, stop at first zero divisor of a divide and clear every word
    always_comb
    begin
        logic [15:0] hi [4];
        logic [15:0] lo [4];
        fault = 1'b0;
        zero  = 1'b0;
        for (int i = 0; i < LANES; i++)
        begin
            used = (i == 0) || ctl_c[CELLS].vector_mode;
            hi[i] = '0;
            lo[i] = '0;
            if (used && !fault)
            begin
                if (ctl_c[CELLS].command == CMD_MUL)
                begin
                    hi[i] = lanes_c[CELLS][i].prod[2*WORD_BITS-1:WORD_BITS];
                    lo[i] = lanes_c[CELLS][i].prod[WORD_BITS-1:0];
                    if (lanes_c[CELLS][i].prod == '0)
                        zero = 1'b1;
                end
                else if (lanes_c[CELLS][i].div == '0)
                    fault = 1'b1;
                else
                begin
                    hi[i] = lanes_c[CELLS][i].quo;
                    lo[i] = lanes_c[CELLS][i].rem;
                    if (hi[i] == '0 && lo[i] == '0)
                        zero = 1'b1;
                end
            end
        end
        if (fault)
        begin
            for (int i = 0; i < LANES; i++)
            begin
                hi[i] = '0;
                lo[i] = '0;
            end
        end
        out_next = '{hi[0], hi[1], hi[2], hi[3], lo[0], lo[1], lo[2], lo[3], zero, fault};
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= ctl_c[DEPTH].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

endmodule

### rtl/smdu_cell.sv
// One cell of the divide chain: one restoring-division step per lane.
// Depends on smdu_pkg.
module smdu_cell (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        en,
    input  smdu_pkg::ctl_t              ctl,
    input  smdu_pkg::lane_t [3:0]       lanes,
    output smdu_pkg::ctl_t              ctl_reg,
    output smdu_pkg::lane_t [3:0]       lanes_reg
);
    import smdu_pkg::*;

    lane_t [3:0] lanes_next;
    logic [WORD_BITS:0] trial [4];

    // Shift in one dividend bit, subtract divisor if it fits
    always_comb
    begin
        for (int i = 0; i < LANES; i++)
        begin
            lanes_next[i] = lanes[i];
            trial[i] = {lanes[i].rem, lanes[i].quo[WORD_BITS-1]} - {1'b0, lanes[i].div};
            if (!trial[i][WORD_BITS])
            begin
                lanes_next[i].rem = trial[i][WORD_BITS-1:0];
                lanes_next[i].quo = {lanes[i].quo[WORD_BITS-2:0], 1'b1};
            end
            else
            begin
                lanes_next[i].rem = {lanes[i].rem[WORD_BITS-2:0], lanes[i].quo[WORD_BITS-1]};
                lanes_next[i].quo = {lanes[i].quo[WORD_BITS-2:0], 1'b0};
            end
        end
    end

    // Advance control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ctl_reg <= '0;
        else if (en)
            ctl_reg <= ctl;
    end

    // Advance payload
    always_ff @(posedge clk)
    begin
        if (en)
            lanes_reg <= lanes_next;
    end

endmodule

### rtl/smdu_checker.sv
// Port-level checks for the SIMD multiply/divide unit, bound to the top level.
// Depends on smdu_pkg.
module smdu_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input smdu_pkg::out_item_t out_data
);
    import smdu_pkg::*;

    // Hold a stalled result
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Fault clears the high and low words of lanes 0 and 3
    a_fault_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.divide_by_zero |->
        out_data.high_lane0 == '0 && out_data.low_lane0 == '0 &&
        out_data.high_lane3 == '0 && out_data.low_lane3 == '0)
        else $error("words not cleared on divide fault");

    // Ready whenever the output is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind simd_mul_div_execute_unit_core smdu_checker u_smdu_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);
